>>> sv/assert_macros.svh
// assertion macros shared by the checker files
// depends on a clock named clock and a reset named reset in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMPLIES(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

>>> sv/pal_pkg.sv
// types, codes and constants of the positional array list unit
// no dependencies
`default_nettype none

package pal_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int CMD_W     = 3;
   localparam int POS_W     = 5;
   localparam int WORD_W    = 32;
   localparam int CNT_OUT_W = 5;
   localparam int CAP_W     = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(5);

   localparam logic [CMD_W-1:0] CMD_INS_FIRST = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INS_LAST  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEL_FIRST = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DEL_LAST  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd5;
   localparam logic [CMD_W-1:0] CMD_READ_POS  = 3'd6;
   localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd7;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [POS_W-1:0]  position;
      logic [WORD_W-1:0] entry_value;
   } req_type;

   typedef struct packed {
      logic                 ok;
      logic [WORD_W-1:0]    read_value;
      logic [CNT_OUT_W-1:0] entry_count;
      logic                 is_full;
      logic                 is_empty;
   } rsp_type;

   // per-beat move broadcast to every slot cell
   typedef struct packed {
      logic ins;
      logic del;
      logic clr;
   } slot_cmd_type;

endpackage

`default_nettype wire

>>> sv/pal_cell.sv
// one slot of the list: holds a word and moves it up or down with its neighbors
// depends on pal_pkg
`default_nettype none

module pal_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W      = 5,
   parameter int SLOT       = 0
) (
   input  wire logic                  clock,
   input  wire pal_pkg::slot_cmd_type ctrl,
   input  wire logic [CNT_W-1:0]      idx,
   input  wire logic [CNT_W-1:0]      count,
   input  wire logic [DATA_WIDTH-1:0] load_word,
   input  wire logic [DATA_WIDTH-1:0] lower_word,
   input  wire logic [DATA_WIDTH-1:0] upper_word,
   output logic      [DATA_WIDTH-1:0] word
);
   import pal_pkg::*;

   localparam logic [CNT_W-1:0] SLOT_C  = CNT_W'(SLOT);
   localparam logic [CNT_W-1:0] SLOT_C1 = CNT_W'(SLOT + 1);

   logic [DATA_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      priority if (ctrl.clr) begin
         word_in = '0;
      end else if (ctrl.ins) begin
         if (SLOT_C == idx) begin
            word_in = load_word;
         end else if (SLOT_C > idx && SLOT_C <= count) begin
            word_in = lower_word;
         end
      end else if (ctrl.del) begin
         if (SLOT_C1 == count) begin
            word_in = '0;
         end else if (SLOT_C >= idx && SLOT_C1 < count) begin
            word_in = upper_word;
         end
      end else begin
         word_in = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

`default_nettype wire

>>> sv/pal_decode.sv
// command decode: checks bounds, picks the slot index and the next count
// depends on pal_pkg
`default_nettype none

module pal_decode #(
   parameter int DEPTH = 16,
   parameter int CNT_W = 5
) (
   input  wire pal_pkg::req_type          req,
   input  wire logic [CNT_W-1:0]          count,
   input  wire logic [pal_pkg::CAP_W-1:0] cap,
   output pal_pkg::slot_cmd_type          ctrl,
   output logic                           ok,
   output logic                           rd,
   output logic [CNT_W-1:0]               idx,
   output logic [CNT_W-1:0]               count_next,
   output logic                           full_next
);
   import pal_pkg::*;

   localparam int CW = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int W  = ((CW > POS_W) ? CW : POS_W) + 1;
   localparam logic [W-1:0] DEPTH_W = W'(DEPTH);

   logic [W-1:0] pos_w;
   logic [W-1:0] cnt_w;
   logic [W-1:0] cap_eff;
   logic         full;
   logic         pos_nz;

   always_comb begin
      pos_w  = W'(req.position);
      cnt_w  = W'(count);
      pos_nz = (req.position != '0);
      if (cap == '0) begin
         cap_eff = W'(1);
      end else if (W'(cap) > DEPTH_W) begin
         cap_eff = DEPTH_W;
      end else begin
         cap_eff = W'(cap);
      end
      full = (cnt_w >= cap_eff);

      ctrl = '0;
      ok   = 1'b0;
      rd   = 1'b0;
      idx  = '0;
      unique case (req.cmd)
         CMD_INS_FIRST: begin
            ok  = !full;
            idx = '0;
         end
         CMD_INS_LAST: begin
            ok  = !full;
            idx = count;
         end
         CMD_INS_POS: begin
            ok  = !full && pos_nz && (pos_w <= cnt_w + W'(1));
            idx = CNT_W'(pos_w - W'(1));
         end
         CMD_DEL_FIRST: begin
            ok  = (count != '0);
            idx = '0;
         end
         CMD_DEL_LAST: begin
            ok  = (count != '0);
            idx = count - CNT_W'(1);
         end
         CMD_DEL_POS: begin
            ok  = pos_nz && (pos_w <= cnt_w);
            idx = CNT_W'(pos_w - W'(1));
         end
         CMD_READ_POS: begin
            ok  = pos_nz && (pos_w <= cnt_w);
            rd  = ok;
            idx = CNT_W'(pos_w - W'(1));
         end
         CMD_CLEAR: begin
            ok       = (count != '0);
            ctrl.clr = 1'b1;
         end
         default: begin
            ok = 1'b0;
         end
      endcase

      ctrl.ins = ok && (req.cmd == CMD_INS_FIRST || req.cmd == CMD_INS_LAST ||
                        req.cmd == CMD_INS_POS);
      ctrl.del = ok && (req.cmd == CMD_DEL_FIRST || req.cmd == CMD_DEL_LAST ||
                        req.cmd == CMD_DEL_POS);

      priority if (ctrl.clr) begin
         count_next = '0;
      end else if (ctrl.ins) begin
         count_next = count + CNT_W'(1);
      end else if (ctrl.del) begin
         count_next = count - CNT_W'(1);
      end else begin
         count_next = count;
      end
      full_next = (W'(count_next) >= cap_eff);
   end

endmodule

`default_nettype wire

>>> sv/positional_array_list_unit.sv
// top level of the positional array list unit: decode, row of slot cells, result register
// depends on pal_pkg, pal_decode and pal_cell
`default_nettype none

// A dense ordered list of up to DEPTH words, held in a row of slot cells.
// Every command beat (start high while busy is low) moves all cells
// together: they shift up, shift down, load or clear at the clock edge,
// so busy never rises and a new beat may follow in every cycle. The result
// beat shows on rsp_item in the cycle after the command, with rsp_valid high
// for exactly that cycle; the receiver cannot stall it, so it must take every
// result as it comes. Inserts are refused when full, deletes and reads when
// empty, and positional commands refuse position zero or a position past the
// end. The capacity register (csr_we / csr_wdata) is clamped to 1..DEPTH and
// resets to 5; lowering it below the current count keeps the entries and the
// list just reads as full. Write it only between commands.
module positional_array_list_unit #(
   parameter int DEPTH      = pal_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = pal_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire pal_pkg::req_type      req_item,
   output logic                       rsp_valid,
   output pal_pkg::rsp_type           rsp_item,
   input  wire logic                  csr_we,
   input  wire logic [pal_pkg::CAP_W-1:0] csr_wdata
);
   import pal_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   // control state
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CAP_W-1:0] cap_ff;
   logic             rsp_valid_ff;
   // result payload, no reset needed
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   logic             accept;
   slot_cmd_type     dec_ctrl;
   slot_cmd_type     cell_ctrl;
   logic             dec_ok;
   logic             dec_rd;
   logic [CNT_W-1:0] dec_idx;
   logic [CNT_W-1:0] dec_count_next;
   logic             dec_full_next;
   logic [DATA_WIDTH-1:0] load_word;
   logic [DATA_WIDTH-1:0] slot_word [DEPTH];
   logic [DATA_WIDTH-1:0] read_word;

   // busy is tied low: no beat is ever held off
   assign busy   = 1'b0;
   assign accept = start && !busy;

   pal_decode #(
      .DEPTH (DEPTH),
      .CNT_W (CNT_W)
   ) u_decode (
      .req        (req_item),
      .count      (count_ff),
      .cap        (cap_ff),
      .ctrl       (dec_ctrl),
      .ok         (dec_ok),
      .rd         (dec_rd),
      .idx        (dec_idx),
      .count_next (dec_count_next),
      .full_next  (dec_full_next)
   );

   // cells move only on an accepted beat
   assign cell_ctrl = accept ? dec_ctrl : '0;
   assign load_word = DATA_WIDTH'(req_item.entry_value);

   // row of slot cells; the ends see zero beyond the list
   for (genvar i = 0; i < DEPTH; i++) begin : g_slot
      logic [DATA_WIDTH-1:0] lower_word;
      logic [DATA_WIDTH-1:0] upper_word;
      if (i == 0) begin : g_bottom
         assign lower_word = '0;
      end else begin : g_lower
         assign lower_word = slot_word[i-1];
      end
      if (i == DEPTH - 1) begin : g_top
         assign upper_word = '0;
      end else begin : g_upper
         assign upper_word = slot_word[i+1];
      end
      pal_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .CNT_W      (CNT_W),
         .SLOT       (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .idx        (dec_idx),
         .count      (count_ff),
         .load_word  (load_word),
         .lower_word (lower_word),
         .upper_word (upper_word),
         .word       (slot_word[i])
      );
   end

   // read select, only for an in-range read
   always_comb begin
      if (dec_rd) begin
         read_word = slot_word[dec_idx[IDX_W-1:0]];
      end else begin
         read_word = '0;
      end
   end

   always_comb begin
      count_in           = accept ? dec_count_next : count_ff;
      rsp_in.ok          = dec_ok;
      rsp_in.read_value  = WORD_W'(read_word);
      rsp_in.entry_count = CNT_OUT_W'(dec_count_next);
      rsp_in.is_full     = dec_full_next;
      rsp_in.is_empty    = (dec_count_next == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

>>> sv/pal_checker.sv
// port-level checker for the positional array list unit, bound to the top level
// depends on pal_pkg, assert_macros.svh and positional_array_list_unit
`include "assert_macros.svh"
`default_nettype none

module pal_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire pal_pkg::rsp_type rsp_item
);
   import pal_pkg::*;

   // each command beat gives a result beat in the next cycle
   `ASSERT_NEXT(a_cmd_gets_rsp, start && !busy, rsp_valid)
   // no result beat without a command beat the cycle before
   `ASSERT_IMPLIES(a_rsp_has_cmd, rsp_valid && !$past(reset), $past(start && !busy))
   // empty flag agrees with the count
   `ASSERT_IMPLIES(a_empty_count, rsp_valid, rsp_item.is_empty == (rsp_item.entry_count == '0))
   // capacity is at least one, so never full and empty at once; read data needs success
   `ASSERT_IMPLIES(a_flags_sane, rsp_valid,
                   !(rsp_item.is_full && rsp_item.is_empty) &&
                   (rsp_item.ok || rsp_item.read_value == '0))

endmodule

bind positional_array_list_unit pal_checker u_pal_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

`default_nettype wire

>>> tb/sv/tb_top.sv
// self-checking testbench for positional_array_list_unit: random bursts of command beats
// checked against an in-bench model of the list. depends on pal_pkg and the unit's rtl
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pal_pkg::*;

   localparam int LIST_DEPTH  = pal_pkg::DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 155;
   localparam int SHOW_LIMIT  = 10;

   // clock, reset and block inputs, all known from time zero
   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   req_type          req_item  = '0;
   logic             csr_we    = 1'b0;
   logic [CAP_W-1:0] csr_wdata = '0;

   logic             busy;
   logic             rsp_valid;
   rsp_type          rsp_item;

   // command beats waiting to go out, and the result beats they should produce
   req_type          send_q[$];
   rsp_type          list_results[$];

   // model of the list: words in slots 0..list_len-1, capacity as last written
   logic [WORD_W-1:0] list_words[LIST_DEPTH];
   int unsigned       list_len;
   logic [CAP_W-1:0]  model_cap;

   int                fault_count;
   int                cycle_count;
   int                gap_left;
   int                burst_left;

   positional_array_list_unit #(
      .DEPTH      (LIST_DEPTH),
      .DATA_WIDTH (DATA_WIDTH_DEFAULT)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // capacity register clamped into 1..depth
   function automatic int unsigned usable_cap(logic [CAP_W-1:0] cap);
      if (cap == 0) return 1;
      if (cap > LIST_DEPTH) return LIST_DEPTH;
      return 32'(cap);
   endfunction

   // open a hole at slot idx and drop the word in, later words move up
   function automatic void open_slot(int unsigned idx, logic [WORD_W-1:0] word);
      for (int unsigned i = list_len; i > idx; i--)
         list_words[i] = list_words[i-1];
      list_words[idx] = word;
      list_len++;
   endfunction

   // remove slot idx, later words move down, vacated slot zeroed
   function automatic void close_slot(int unsigned idx);
      for (int unsigned i = idx; i + 1 < list_len; i++)
         list_words[i] = list_words[i+1];
      list_words[list_len-1] = '0;
      list_len--;
   endfunction

   // apply one command to the model and return the result beat it gives
   function automatic rsp_type apply_list_cmd(req_type r);
      rsp_type     res;
      int unsigned cap_eff;
      int unsigned p;
      logic        full;
      res     = '0;
      cap_eff = usable_cap(model_cap);
      full    = (list_len >= cap_eff);
      p       = 32'(r.position);
      case (r.cmd)
         CMD_INS_FIRST: begin
            if (!full) begin
               open_slot(0, r.entry_value);
               res.ok = 1'b1;
            end
         end
         CMD_INS_LAST: begin
            if (!full) begin
               open_slot(list_len, r.entry_value);
               res.ok = 1'b1;
            end
         end
         CMD_INS_POS: begin
            if (!full && p >= 1 && p <= list_len + 1) begin
               open_slot(p - 1, r.entry_value);
               res.ok = 1'b1;
            end
         end
         CMD_DEL_FIRST: begin
            if (list_len > 0) begin
               close_slot(0);
               res.ok = 1'b1;
            end
         end
         CMD_DEL_LAST: begin
            if (list_len > 0) begin
               close_slot(list_len - 1);
               res.ok = 1'b1;
            end
         end
         CMD_DEL_POS: begin
            if (p >= 1 && p <= list_len) begin
               close_slot(p - 1);
               res.ok = 1'b1;
            end
         end
         CMD_READ_POS: begin
            if (p >= 1 && p <= list_len) begin
               res.read_value = list_words[p-1];
               res.ok         = 1'b1;
            end
         end
         default: begin
            // clear: ok only when something was held
            res.ok = (list_len > 0);
            foreach (list_words[i]) list_words[i] = '0;
            list_len = 0;
         end
      endcase
      res.entry_count = CNT_OUT_W'(list_len);
      res.is_full     = (list_len >= cap_eff);
      res.is_empty    = (list_len == 0);
      return res;
   endfunction

   // driver: takes a beat when start meets a low busy, then picks the next
   // beat from the queue in bursts with random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         start      <= 1'b0;
         list_len   = 0;
         model_cap  = CAP_RESET;
         gap_left   = 0;
         burst_left = $urandom_range(1, 24);
         foreach (list_words[i]) list_words[i] = '0;
      end else begin
         // register write seen at the same edge as the block sees it
         if (csr_we)
            model_cap = csr_wdata;
         if (start && !busy)
            list_results.push_back(apply_list_cmd(req_item));
         // a refused handshake keeps the same beat on the port
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (send_q.size() != 0) begin
               req_item <= send_q.pop_front();
               start    <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  // now and then a long unbroken stretch, otherwise short gaps
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                           : $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every strobed result beat is matched to the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (list_results.size() == 0) begin
            fault_count++;
            if (fault_count <= SHOW_LIMIT)
               $display("unexpected result beat: ok=%0d rd=%h cnt=%0d full=%0d empty=%0d",
                        rsp_item.ok, rsp_item.read_value, rsp_item.entry_count,
                        rsp_item.is_full, rsp_item.is_empty);
         end else begin
            want = list_results.pop_front();
            if (rsp_item.ok !== want.ok || rsp_item.read_value !== want.read_value ||
                rsp_item.entry_count !== want.entry_count ||
                rsp_item.is_full !== want.is_full || rsp_item.is_empty !== want.is_empty) begin
               fault_count++;
               if (fault_count <= SHOW_LIMIT) begin
                  $write("mismatch: expected ok=%0d rd=%h cnt=%0d full=%0d empty=%0d,",
                         want.ok, want.read_value, want.entry_count, want.is_full,
                         want.is_empty);
                  $display(" got ok=%0d rd=%h cnt=%0d full=%0d empty=%0d",
                           rsp_item.ok, rsp_item.read_value, rsp_item.entry_count,
                           rsp_item.is_full, rsp_item.is_empty);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic queue_cmd(logic [CMD_W-1:0] cmd, int pos, logic [WORD_W-1:0] val);
      req_type r;
      r.cmd         = cmd;
      r.position    = POS_W'(pos);
      r.entry_value = val;
      send_q.push_back(r);
   endtask

   // sender pauses until every queued beat is out and every result is back
   task automatic wait_idle();
      do @(posedge clock);
      while (send_q.size() != 0 || start || list_results.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // random beat: mostly in-range positions for the current capacity,
   // some position zero and some anywhere in the field
   task automatic queue_random(int unsigned cap_eff, int unsigned ins_weight);
      int unsigned      r;
      int unsigned      pick;
      int               pos;
      logic [CMD_W-1:0] cmd;
      r    = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      if (r < 3)
         cmd = CMD_CLEAR;
      else if (r < 3 + ins_weight)
         cmd = CMD_W'($urandom_range(CMD_INS_FIRST, CMD_INS_POS));
      else if (r < 21 + ins_weight)
         cmd = CMD_READ_POS;
      else
         cmd = CMD_W'($urandom_range(CMD_DEL_FIRST, CMD_DEL_POS));
      if (pick < 75)
         pos = $urandom_range(1, cap_eff + 1);
      else if (pick < 85)
         pos = 0;
      else
         pos = $urandom_range(0, 31);
      queue_cmd(cmd, pos, $urandom);
   endtask

   initial begin
      logic [CAP_W-1:0] cap_plan[10];
      int unsigned      ins_weight;
      cap_plan = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd12, 5'd17, 5'd2, 5'd8, 5'd16};
      fault_count = 0;
      cycle_count = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed beats at the reset capacity of five
      // empty list: reads, deletes and clear all refused
      queue_cmd(CMD_READ_POS,  1,  32'h0000_0001);
      queue_cmd(CMD_DEL_FIRST, 1,  32'h0);
      queue_cmd(CMD_DEL_LAST,  1,  32'h0);
      queue_cmd(CMD_DEL_POS,   1,  32'h0);
      queue_cmd(CMD_CLEAR,     0,  32'h0);
      // position zero and position past count+1 refused for insert
      queue_cmd(CMD_INS_POS,   0,  32'h1111_1111);
      queue_cmd(CMD_INS_POS,   2,  32'h2222_2222);
      // fill to full with extreme words, positional insert at count+1
      queue_cmd(CMD_INS_POS,   1,  32'hFFFF_FFFF);
      queue_cmd(CMD_INS_FIRST, 0,  32'h0000_0000);
      queue_cmd(CMD_INS_LAST,  0,  32'hA5A5_A5A5);
      queue_cmd(CMD_INS_POS,   4,  32'h5A5A_5A5A);
      queue_cmd(CMD_INS_POS,   3,  32'h1234_5678);
      // inserts refused when full
      queue_cmd(CMD_INS_LAST,  0,  32'hDEAD_BEEF);
      queue_cmd(CMD_INS_FIRST, 0,  32'hDEAD_BEEF);
      // reads: zero, both ends, past the end, field maximum
      queue_cmd(CMD_READ_POS,  0,  32'h0);
      queue_cmd(CMD_READ_POS,  1,  32'h0);
      queue_cmd(CMD_READ_POS,  5,  32'h0);
      queue_cmd(CMD_READ_POS,  6,  32'h0);
      queue_cmd(CMD_READ_POS,  31, 32'h0);
      // deletes: refused positions, then middle, front and back
      queue_cmd(CMD_DEL_POS,   0,  32'h0);
      queue_cmd(CMD_DEL_POS,   6,  32'h0);
      queue_cmd(CMD_DEL_POS,   3,  32'h0);
      queue_cmd(CMD_DEL_FIRST, 0,  32'h0);
      queue_cmd(CMD_DEL_LAST,  0,  32'h0);
      // clear with entries still held
      queue_cmd(CMD_CLEAR,     17, 32'hFFFF_FFFF);
      wait_idle();

      // random phases, capacity rewritten while idle; the list is left
      // partly filled across a write so a lowered capacity meets a bigger count
      foreach (cap_plan[k]) begin
         write_capacity(cap_plan[k]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0)
               ins_weight = $urandom_range(25, 70);
            queue_random(usable_cap(cap_plan[k]), ins_weight);
         end
         // top the list up before the next capacity change
         repeat (8) queue_cmd(CMD_INS_LAST, 0, $urandom);
         wait_idle();
      end

      if (fault_count == 0 && list_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
